// ===== rtl/core/crc32wc_pkg.sv =====
// Package for the CRC-32 word checksum core: polynomial, start value and
// the constant update matrix of one 32-bit word step.
// No dependencies; imported by crc32wc_fold and crc32_word_checksum_core.
package crc32wc_pkg;

  localparam int unsigned CrcWidth = 32;

  localparam logic [CrcWidth-1:0] CrcInit = 32'hFFFF_FFFF;
  localparam logic [CrcWidth-1:0] CrcPoly = 32'h04C1_1DB7;
  localparam logic [CrcWidth-1:0] CrcTop  = 32'h8000_0000;

  // Row i holds the bits of (register xor word) that feed result bit i.
  typedef logic [CrcWidth-1:0][CrcWidth-1:0] crc_matrix_t;

  // Bit-serial fold of a 32-bit value with zero data, MSB first.
  // Since the data bit enters where the top bit leaves, folding (crc, word)
  // equals folding (crc ^ word, 0), so one map covers both.
  function automatic logic [CrcWidth-1:0] crc_fold_serial(logic [CrcWidth-1:0] value);
    logic [CrcWidth-1:0] crc;
    logic                top;
    crc = value;
    for (int k = 0; k < CrcWidth; k++) begin
      top = |(crc & CrcTop);
      crc = {crc[CrcWidth-2:0], 1'b0};
      if (top) begin
        crc = crc ^ CrcPoly;
      end
    end
    return crc;
  endfunction

  // Build the update matrix from the response to each unit vector.
  function automatic crc_matrix_t crc_fold_matrix();
    crc_matrix_t         mat;
    logic [CrcWidth-1:0] col;
    mat = '0;
    for (int j = 0; j < CrcWidth; j++) begin
      col = crc_fold_serial(CrcWidth'(1) << j);
      for (int i = 0; i < CrcWidth; i++) begin
        mat[i][j] = col[i];
      end
    end
    return mat;
  endfunction

endpackage

// ===== rtl/core/crc32wc_fold.sv =====
// One-word CRC-32 update as a flat XOR network.
// Depends on crc32wc_pkg for the constant update matrix.
module crc32wc_fold (
  input  logic [crc32wc_pkg::CrcWidth-1:0] crc_i,
  input  logic [crc32wc_pkg::CrcWidth-1:0] data_i,
  output logic [crc32wc_pkg::CrcWidth-1:0] crc_o
);
  import crc32wc_pkg::*;

  localparam crc_matrix_t FoldMatrix = crc_fold_matrix();

  logic [CrcWidth-1:0] mixed;

  // The data word lines up with the register bits as they shift out.
  assign mixed = crc_i ^ data_i;

  // Each result bit is the parity of its selected input bits.
  always_comb begin
    for (int i = 0; i < CrcWidth; i++) begin
      crc_o[i] = ^(FoldMatrix[i] & mixed);
    end
  end

endmodule

// ===== rtl/core/crc32_word_checksum_core.sv =====
// Top level of the CRC-32 (MPEG-2 form) checksum core over 32-bit words.
// Depends on crc32wc_pkg and crc32wc_fold.
//
//  Channel  | Signals                                   | Direction
//  ---------+-------------------------------------------+----------
//  input    | in_valid_i, in_stall_o, data_word_i,      | in
//           | last_word_i                               |
//  output   | out_valid_o, out_stall_i, checksum_o      | out
//
// One word per cycle unless stalled; the XOR fold network sets the cycle path.
// The last word is registered, then folded into the result register.
// Reset returns the running register to all ones and empties both stages.
// The input side stalls only when a last word waits and the result
// register still holds an untaken checksum under stall.
module crc32_word_checksum_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [crc32wc_pkg::CrcWidth-1:0]  data_word_i,
  input  logic                              last_word_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [crc32wc_pkg::CrcWidth-1:0]  checksum_o
);
  import crc32wc_pkg::*;

  logic                in_valid_q;
  logic [CrcWidth-1:0] data_q;
  logic                last_q;
  logic [CrcWidth-1:0] running_q;
  logic [CrcWidth-1:0] running_d;
  logic                out_valid_q;
  logic [CrcWidth-1:0] checksum_q;
  logic [CrcWidth-1:0] fold_crc;
  logic                out_free;
  logic                fold_fire;

  // The result register can take a checksum this cycle.
  assign out_free  = !out_valid_q || !out_stall_i;
  // The registered word moves through the fold stage.
  assign fold_fire = in_valid_q && (!last_q || out_free);
  assign in_stall_o = in_valid_q && !fold_fire;

  // Input register, loaded on each transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      data_q <= data_word_i;
      last_q <= last_word_i;
    end
  end

  crc32wc_fold u_fold (
    .crc_i  (running_q),
    .data_i (data_q),
    .crc_o  (fold_crc)
  );

  // Running register restarts from all ones after each message.
  always_comb begin
    running_d = running_q;
    if (fold_fire) begin
      running_d = last_q ? CrcInit : fold_crc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= CrcInit;
    end else begin
      running_q <= running_d;
    end
  end

  // Result register holds the checksum until its transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fold_fire && last_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fold_fire && last_q) begin
      checksum_q <= fold_crc;
    end
  end

  assign out_valid_o = out_valid_q;
  assign checksum_o  = checksum_q;

`ifndef ASSERT_OFF
  // A finished message leaves the running register at its start value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fold_fire && last_q |=> running_q == CrcInit)
    else $error("running CRC not restarted after last word");

  // The checksum of a last word lands in the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fold_fire && last_q |=> out_valid_q && checksum_q == $past(fold_crc))
    else $error("checksum not captured for last word");

  // Input stalls only when a last word is blocked by a held result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && last_q && out_valid_q && out_stall_i)
    else $error("input stalled without a blocked result");
`endif

endmodule
